// ===== hw/rtl/xxh32_pkg.sv =====
package xxh32_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned COUNT_W     = 3;
  localparam int unsigned LANES       = 4;
  localparam int unsigned STRIPE_B    = 16;
  localparam logic [2:0]  BYTES_PER_ITEM = 3'd4;

  localparam logic [31:0] PRIME1 = 32'h9E3779B1;
  localparam logic [31:0] PRIME2 = 32'h85EBCA77;
  localparam logic [31:0] PRIME3 = 32'hC2B2AE3D;
  localparam logic [31:0] PRIME4 = 32'h27D4EB2F;
  localparam logic [31:0] PRIME5 = 32'h165667B1;

  // register byte addresses (bit 2 upward selects the register)
  localparam logic SEED_IDX = 1'b0;

  typedef struct packed {
    logic [3:0][31:0] acc;
    logic [31:0]      total_length;
    logic             long_message;
    logic [3:0]       tail_count;
    logic [15:0][7:0] tail;
  } fin_snap_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
    logic [63:0] d;
    d = {x, x} << r;
    return d[63:32];
  endfunction

endpackage

// ===== hw/rtl/xxh32_item_if.sv =====
interface xxh32_item_if;
  logic                              valid;
  logic                              ready;
  logic [xxh32_pkg::DATA_W-1:0]      data_word;
  logic [xxh32_pkg::COUNT_W-1:0]     byte_count;
  logic                              last;

  modport source (output valid, data_word, byte_count, last, input ready);
  modport sink   (input valid, data_word, byte_count, last, output ready);
endinterface

// ===== hw/rtl/xxh32_hash_if.sv =====
interface xxh32_hash_if;
  logic                          valid;
  logic                          ready;
  logic [xxh32_pkg::DATA_W-1:0]  hash;

  modport source (output valid, hash, input ready);
  modport sink   (input valid, hash, output ready);
endinterface

// ===== hw/rtl/xxh32_lane.sv =====
module xxh32_lane (
  input  logic        clk,
  input  logic        rst,
  input  logic        init,
  input  logic [31:0] init_val,
  input  logic        start,
  input  logic [31:0] word,
  output logic [31:0] acc,
  output logic        busy
);

  typedef enum logic [1:0] {L_IDLE, L_ROT, L_MUL} lane_state_t;

  lane_state_t state;
  logic [31:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      unique case (state)
        L_IDLE: if (start) state <= L_ROT;
        L_ROT:  state <= L_MUL;
        L_MUL:  state <= L_IDLE;
        default: state <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (init) begin
      acc <= init_val;
    end else if (state == L_ROT) begin
      acc <= xxh32_pkg::rotl32(acc + prod, 13);
    end else if (state == L_MUL) begin
      acc <= acc * xxh32_pkg::PRIME1;
    end
    if (start) prod <= word * xxh32_pkg::PRIME2;
  end

  assign busy = (state != L_IDLE);

endmodule

// ===== hw/rtl/xxh32_merge.sv =====
module xxh32_merge (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  xxh32_pkg::fin_snap_t  snap,
  output logic                  res_valid,
  output logic [31:0]           res_hash,
  input  logic                  res_ready,
  output logic                  busy
);

  typedef enum logic [3:0] {
    F_IDLE, F_WMUL, F_WROT, F_WFIN, F_BMUL, F_BROT, F_BFIN,
    F_AV1, F_AV2, F_AV3, F_DONE
  } fin_state_t;

  fin_state_t  state;
  logic [31:0] h;
  logic [31:0] m;
  logic [3:0]  pos;
  logic [3:0]  left;
  logic [31:0] h0;
  logic [31:0] word_sel;
  logic [7:0]  byte_sel;
  logic [3:0]  left_w;
  logic [3:0]  left_b;

  function automatic fin_state_t pick(input logic [3:0] n);
    if (n >= 4'd4) return F_WMUL;
    else if (n != 4'd0) return F_BMUL;
    else return F_AV1;
  endfunction

  always_comb begin
    if (snap.long_message) begin
      h0 = xxh32_pkg::rotl32(snap.acc[0], 1) + xxh32_pkg::rotl32(snap.acc[1], 7) +
           xxh32_pkg::rotl32(snap.acc[2], 12) + xxh32_pkg::rotl32(snap.acc[3], 18);
    end else begin
      h0 = snap.acc[2] + xxh32_pkg::PRIME5;
    end
    h0 = h0 + snap.total_length;
    word_sel = {snap.tail[{pos[3:2], 2'd3}], snap.tail[{pos[3:2], 2'd2}],
                snap.tail[{pos[3:2], 2'd1}], snap.tail[{pos[3:2], 2'd0}]};
    byte_sel = snap.tail[pos];
    left_w   = left - 4'd4;
    left_b   = left - 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: if (start) state <= pick(snap.tail_count);
        F_WMUL: state <= F_WROT;
        F_WROT: state <= F_WFIN;
        F_WFIN: state <= pick(left_w);
        F_BMUL: state <= F_BROT;
        F_BROT: state <= F_BFIN;
        F_BFIN: state <= pick(left_b);
        F_AV1:  state <= F_AV2;
        F_AV2:  state <= F_AV3;
        F_AV3:  state <= F_DONE;
        F_DONE: if (res_ready) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        h    <= h0;
        pos  <= 4'd0;
        left <= snap.tail_count;
      end
      F_WMUL: m <= word_sel * xxh32_pkg::PRIME3;
      F_WROT: h <= xxh32_pkg::rotl32(h + m, 17);
      F_WFIN: begin
        h    <= h * xxh32_pkg::PRIME4;
        pos  <= pos + 4'd4;
        left <= left_w;
      end
      F_BMUL: m <= {24'd0, byte_sel} * xxh32_pkg::PRIME5;
      F_BROT: h <= xxh32_pkg::rotl32(h + m, 11);
      F_BFIN: begin
        h    <= h * xxh32_pkg::PRIME1;
        pos  <= pos + 4'd1;
        left <= left_b;
      end
      F_AV1: h <= (h ^ (h >> 15)) * xxh32_pkg::PRIME2;
      F_AV2: h <= (h ^ (h >> 13)) * xxh32_pkg::PRIME3;
      F_AV3: h <= h ^ (h >> 16);
      default: h <= h;
    endcase
  end

  assign res_valid = (state == F_DONE);
  assign res_hash  = h;
  assign busy      = (state != F_IDLE);

endmodule

// ===== hw/rtl/xxhash32_stream_hasher.sv =====
// Channel   Dir  Payload                          Beat taken when
// item      in   data_word, byte_count, last      item.valid && item.ready
// result    out  hash                             result.valid && result.ready
// apb       in   seed register at address 0       psel && penable && pwrite
//
// A beat that does not complete a stripe and is not last is only buffered.
// A beat that completes a 16-byte stripe holds off input while the four lane units
// run the round in parallel: multiply at the accepting edge, then rotate, then multiply.
// A last beat starts the merge unit: a fold step, a multiply, rotate and multiply step
// per tail word and per tail byte, and the avalanche steps, one merge step per cycle.
// Reset clears the seed to zero; a seed write restarts the message.
// A digest held in the output register does not stall input; only the next
// digest waits for it to be taken.
module xxhash32_stream_hasher (
  input  logic               clk,
  input  logic               rst,
  xxh32_item_if.sink         item,
  xxh32_hash_if.source       result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [31:0]      seed;
  logic [3:0]       buffered_count;
  logic [31:0]      total_length;
  logic             long_message;
  logic [15:0][7:0] stripe_buffer;
  logic             pend;
  logic             out_valid;
  logic [31:0]      out_hash;

  logic             seed_wr;
  logic [31:0]      seed_eff;
  logic             lane_init;
  logic [3:0][31:0] init_vals;
  logic [2:0]       n;
  logic [4:0]       fill;
  logic             accept;
  logic             stripe_done;
  logic [15:0][7:0] stripe;
  logic [3:0][7:0]  in_bytes;
  logic [3:0][31:0] lane_acc;
  logic [3:0]       lane_busy;
  logic             fin_start;
  logic             fin_busy;
  logic             fin_valid;
  logic [31:0]      fin_hash;
  logic             fin_ready;
  logic             fin_fire;
  xxh32_pkg::fin_snap_t snap;

  assign pready   = 1'b1;
  assign seed_wr  = psel && penable && pwrite && (paddr[2] == xxh32_pkg::SEED_IDX);
  assign prdata   = (paddr[2] == xxh32_pkg::SEED_IDX) ? seed : 32'd0;
  assign seed_eff = rst ? 32'd0 : (seed_wr ? pwdata : seed);

  assign fin_ready = !out_valid || result.ready;
  assign fin_fire  = fin_valid && fin_ready;
  assign lane_init = rst || seed_wr || fin_fire;

  assign init_vals[0] = seed_eff + xxh32_pkg::PRIME1 + xxh32_pkg::PRIME2;
  assign init_vals[1] = seed_eff + xxh32_pkg::PRIME2;
  assign init_vals[2] = seed_eff;
  assign init_vals[3] = seed_eff - xxh32_pkg::PRIME1;

  assign item.ready = !pend && !(|lane_busy) && !fin_busy;
  assign accept     = item.valid && item.ready;
  assign in_bytes   = item.data_word;
  assign n          = (item.byte_count > xxh32_pkg::BYTES_PER_ITEM) ?
                      xxh32_pkg::BYTES_PER_ITEM : item.byte_count;
  assign fill        = {1'b0, buffered_count} + {2'd0, n};
  assign stripe_done = fill[4];
  assign fin_start   = pend && !(|lane_busy) && !fin_busy;

  // merge held bytes with the new ones to form the completed stripe
  always_comb begin
    for (int j = 0; j < xxh32_pkg::STRIPE_B; j++) begin
      if (4'(j) < buffered_count) begin
        stripe[j] = stripe_buffer[j];
      end else begin
        stripe[j] = in_bytes[2'(4'(j) - buffered_count)];
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < xxh32_pkg::LANES; g++) begin : g_lane
      xxh32_lane u_lane (
        .clk      (clk),
        .rst      (rst),
        .init     (lane_init),
        .init_val (init_vals[g]),
        .start    (accept && stripe_done),
        .word     ({stripe[4*g+3], stripe[4*g+2], stripe[4*g+1], stripe[4*g]}),
        .acc      (lane_acc[g]),
        .busy     (lane_busy[g])
      );
    end
  endgenerate

  assign snap.acc          = lane_acc;
  assign snap.total_length = total_length;
  assign snap.long_message = long_message;
  assign snap.tail_count   = buffered_count;
  assign snap.tail         = stripe_buffer;

  xxh32_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .start     (fin_start),
    .snap      (snap),
    .res_valid (fin_valid),
    .res_hash  (fin_hash),
    .res_ready (fin_ready),
    .busy      (fin_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seed           <= 32'd0;
      buffered_count <= 4'd0;
      total_length   <= 32'd0;
      long_message   <= 1'b0;
      pend           <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (seed_wr) seed <= pwdata;
      if (fin_start) pend <= 1'b0;
      if (seed_wr || fin_fire) begin
        buffered_count <= 4'd0;
        total_length   <= 32'd0;
        long_message   <= 1'b0;
      end else if (accept) begin
        buffered_count <= fill[3:0];
        total_length   <= total_length + {29'd0, n};
        long_message   <= long_message || stripe_done;
        if (item.last) pend <= 1'b1;
      end
      if (fin_fire) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < n) stripe_buffer[buffered_count + 4'(i)] <= in_bytes[i];
      end
    end
    if (fin_fire) out_hash <= fin_hash;
  end

  assign result.valid = out_valid;
  assign result.hash  = out_hash;

endmodule

// ===== hw/rtl/xxh32_checker.sv =====
module xxh32_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_hash,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  // a stalled digest holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_hash))
    else $error("digest dropped or changed while stalled");

  // the beat closing a message blocks input until the merge unit has passed on its digest
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken right after a last beat");

  a_seed_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && (paddr[2] == xxh32_pkg::SEED_IDX) |=>
      (paddr[2] != xxh32_pkg::SEED_IDX) || (prdata == $past(pwdata)))
    else $error("seed readback mismatch");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("digest valid straight after reset");

endmodule

bind xxhash32_stream_hasher xxh32_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .in_last   (item.last),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_hash  (result.hash),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
